/* rtl/decimal_literal_to_typed_bits_defines.svh */
// assertion macros for the checker file
`ifndef DECIMAL_LITERAL_TO_TYPED_BITS_DEFINES_SVH
`define DECIMAL_LITERAL_TO_TYPED_BITS_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DLTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DLTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dltb_pkg.sv */
package dltb_pkg;

    localparam int ACC_W = 64;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // largest accumulator that can take one more digit without wrapping
    localparam logic [ACC_W-1:0] ACC_LIM   = 64'd1844674407370955161;
    localparam logic [3:0]       LIM_DIGIT = 4'd5;

    typedef enum logic [3:0] {
        TC_BYTE = 4'd0,
        TC_U8   = 4'd1,
        TC_I8   = 4'd2,
        TC_U16  = 4'd3,
        TC_I16  = 4'd4,
        TC_U32  = 4'd5,
        TC_I32  = 4'd6,
        TC_U64  = 4'd7,
        TC_I64  = 4'd8,
        TC_F32  = 4'd9,
        TC_F64  = 4'd10
    } t_type_code;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_INT      = 3'd1,
        ST_EMPTY_BAD    = 3'd2,
        ST_NEG_UNSIGNED = 3'd3,
        ST_RANGE        = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SZ_8  = 2'd0,
        SZ_16 = 2'd1,
        SZ_32 = 2'd2,
        SZ_64 = 2'd3
    } t_size;

    typedef struct packed {
        logic [7:0] digit_char;
        logic       is_last;
        logic       empty_literal;
        logic       negative;
        logic [3:0] type_code;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [2:0]  status;
    } t_out_item;

    // literal as it stands after its terminating character
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             overflow;
        logic             bad_char;
        logic             empty;
        logic             negative;
        logic [3:0]       type_code;
    } t_snap;

    typedef struct packed {
        logic  is_int;
        logic  is_signed;
        t_size size;
    } t_type_info;

    function automatic t_type_info type_info(input logic [3:0] code);
        t_type_info ti;
        ti = '{is_int: 1'b1, is_signed: 1'b0, size: SZ_8};
        case (code)
            TC_BYTE, TC_U8: ti.size = SZ_8;
            TC_I8:          begin ti.size = SZ_8;  ti.is_signed = 1'b1; end
            TC_U16:         ti.size = SZ_16;
            TC_I16:         begin ti.size = SZ_16; ti.is_signed = 1'b1; end
            TC_U32:         ti.size = SZ_32;
            TC_I32:         begin ti.size = SZ_32; ti.is_signed = 1'b1; end
            TC_U64:         ti.size = SZ_64;
            TC_I64:         begin ti.size = SZ_64; ti.is_signed = 1'b1; end
            default:        ti.is_int = 1'b0;
        endcase
        return ti;
    endfunction

    function automatic logic [ACC_W-1:0] width_mask(input t_size sz);
        logic [ACC_W-1:0] m;
        case (sz)
            SZ_8:    m = 64'h0000_0000_0000_00FF;
            SZ_16:   m = 64'h0000_0000_0000_FFFF;
            SZ_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // 2^(w-1), the magnitude of the most negative value
    function automatic logic [ACC_W-1:0] sign_half(input t_size sz);
        logic [ACC_W-1:0] h;
        case (sz)
            SZ_8:    h = 64'h0000_0000_0000_0080;
            SZ_16:   h = 64'h0000_0000_0000_8000;
            SZ_32:   h = 64'h0000_0000_8000_0000;
            default: h = 64'h8000_0000_0000_0000;
        endcase
        return h;
    endfunction

endpackage

/* rtl/dltb_accum.sv */
module dltb_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dltb_pkg::t_in_item i_item,
    input  logic              i_snap_take,
    output logic              o_snap_valid,
    output dltb_pkg::t_snap   o_snap
);

    logic [dltb_pkg::ACC_W-1:0] r_acc;
    logic                       r_ovf;
    logic                       r_bad;
    logic                       r_snap_valid;
    dltb_pkg::t_snap            r_snap;

    logic                       is_digit;
    logic [3:0]                 digit;
    logic                       ovf_now;
    logic                       term;
    logic [dltb_pkg::ACC_W-1:0] acc_x10;
    logic [dltb_pkg::ACC_W-1:0] n_acc;
    logic                       n_ovf;
    logic                       n_bad;

    always_comb begin
        is_digit = (i_item.digit_char >= dltb_pkg::CH_ZERO) &&
                   (i_item.digit_char <= dltb_pkg::CH_NINE);
        digit    = i_item.digit_char[3:0];
        // times ten as two shifted copies
        acc_x10  = {r_acc[dltb_pkg::ACC_W-4:0], 3'b000} +
                   {r_acc[dltb_pkg::ACC_W-2:0], 1'b0} +
                   {{(dltb_pkg::ACC_W-4){1'b0}}, digit};
        ovf_now  = is_digit && ((r_acc > dltb_pkg::ACC_LIM) ||
                   ((r_acc == dltb_pkg::ACC_LIM) && (digit > dltb_pkg::LIM_DIGIT)));
        n_acc    = is_digit ? acc_x10 : r_acc;
        n_ovf    = r_ovf | ovf_now;
        n_bad    = r_bad | ~is_digit;
        term     = i_item.empty_literal | i_item.is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_ovf        <= 1'b0;
            r_bad        <= 1'b0;
            r_snap_valid <= 1'b0;
        end else begin
            if (i_load && term) begin
                r_acc        <= '0;
                r_ovf        <= 1'b0;
                r_bad        <= 1'b0;
                r_snap_valid <= 1'b1;
            end else begin
                if (i_load) begin
                    r_acc <= n_acc;
                    r_ovf <= n_ovf;
                    r_bad <= n_bad;
                end
                if (i_snap_take) begin
                    r_snap_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && term) begin
            r_snap.acc       <= n_acc;
            r_snap.overflow  <= n_ovf;
            r_snap.bad_char  <= n_bad;
            r_snap.empty     <= i_item.empty_literal;
            r_snap.negative  <= i_item.negative;
            r_snap.type_code <= i_item.type_code;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

/* rtl/dltb_check.sv */
module dltb_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dltb_pkg::t_snap     i_snap,
    input  logic                i_out_take,
    output logic                o_valid,
    output dltb_pkg::t_out_item o_item
);

    dltb_pkg::t_type_info       ti;
    logic [dltb_pkg::ACC_W-1:0] mask;
    logic [dltb_pkg::ACC_W-1:0] maximum;
    logic [dltb_pkg::ACC_W-1:0] signed_bits;
    dltb_pkg::t_status          status;
    dltb_pkg::t_out_item        n_item;
    logic                       r_valid;
    dltb_pkg::t_out_item        r_item;

    always_comb begin
        ti          = dltb_pkg::type_info(i_snap.type_code);
        mask        = dltb_pkg::width_mask(ti.size);
        if (ti.is_signed) begin
            maximum = dltb_pkg::sign_half(ti.size) -
                      {{(dltb_pkg::ACC_W-1){1'b0}}, ~i_snap.negative};
        end else begin
            maximum = mask;
        end
        signed_bits = i_snap.negative ? ('0 - i_snap.acc) : i_snap.acc;

        if (!ti.is_int) begin
            status = dltb_pkg::ST_NOT_INT;
        end else if (i_snap.empty || i_snap.bad_char) begin
            status = dltb_pkg::ST_EMPTY_BAD;
        end else if (i_snap.negative && !ti.is_signed) begin
            status = dltb_pkg::ST_NEG_UNSIGNED;
        end else if (i_snap.overflow || (i_snap.acc > maximum)) begin
            status = dltb_pkg::ST_RANGE;
        end else begin
            status = dltb_pkg::ST_OK;
        end

        n_item.status     = status;
        n_item.value_bits = (status == dltb_pkg::ST_OK) ? (signed_bits & mask) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/decimal_literal_to_typed_bits.sv */
// Decimal literal to typed bits: characters of an unsigned decimal literal
// come in one per transaction, most significant first, and are folded into a
// 64-bit accumulator as value*10+digit; the transaction flagged is_last (or
// one flagged empty_literal) also carries the sign and the target type code,
// and produces exactly one result transaction with the two's complement bits
// masked to the type width, or zero bits with an error status. A new
// character is taken every cycle while o_stall is low; the multiply-by-ten
// update of the accumulator (two shifts and a three-input 64-bit add) is the
// only arithmetic loop. A terminating character passes through the input
// register, the final-value register and the result register, in that
// order. A stall on the result side backs up through those three registers
// before the input side sees stall.
module decimal_literal_to_typed_bits (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dltb_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output dltb_pkg::t_out_item o_data
);

    // input register
    logic               r_in_valid;
    dltb_pkg::t_in_item r_in;

    // handshake between the stages
    logic               in_accept;
    logic               in_term;
    logic               in_move;
    logic               snap_valid;
    dltb_pkg::t_snap    snap;
    logic               out_ready;
    logic               snap_take;
    logic               snap_ready;
    logic               out_take;

    assign out_take   = o_valid & ~i_stall;
    // result register free, or emptied this cycle
    assign out_ready  = ~o_valid | ~i_stall;
    assign snap_take  = snap_valid & out_ready;
    assign snap_ready = ~snap_valid | out_ready;

    // only a terminating character needs room in the final-value register
    assign in_term    = r_in.empty_literal | r_in.is_last;
    assign in_move    = r_in_valid & (~in_term | snap_ready);
    assign o_stall    = r_in_valid & ~in_move;
    assign in_accept  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (in_move) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_data;
        end
    end

    // accumulator, sticky flags and the final-value register
    dltb_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_move),
        .i_item       (r_in),
        .i_snap_take  (snap_take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    // type, sign and range checks into the result register
    dltb_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (snap_take),
        .i_snap     (snap),
        .i_out_take (out_take),
        .o_valid    (o_valid),
        .o_item     (o_data)
    );

endmodule

/* rtl/dltb_sva.sv */
`include "decimal_literal_to_typed_bits_defines.svh"

module dltb_sva (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input dltb_pkg::t_in_item  i_data,
    input logic                o_valid,
    input logic                i_stall,
    input dltb_pkg::t_out_item o_data
);

    // a stalled result holds
    `DLTB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "result changed while stalled")

    // a stalled input transaction holds
    `DLTB_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_data), "input changed while stalled")

    // error results carry zero bits
    `DLTB_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && (o_data.status != dltb_pkg::ST_OK), o_data.value_bits == 64'd0, "nonzero bits on an error result")

    // status is one of the defined codes
    `DLTB_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_valid, o_data.status <= dltb_pkg::ST_RANGE, "undefined status code")

    // input side only stalls while the result side is backed up
    `DLTB_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled with result side free")

endmodule

bind decimal_literal_to_typed_bits dltb_sva u_dltb_sva (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
